>>> src/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types and constants for the keyed slot table.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int unsigned DefSlots = 16;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned InfoW    = 64;

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_LOOKUP  = 2'd1,
    ACT_ERASE   = 2'd2,
    ACT_COMPACT = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic    load;
    logic    adv_rd;
    logic    adv_wr;
    logic    add_slot;
    logic    move_slot;
    logic    free_slot;
    logic    set_status;
    status_e status;
    logic    set_info;
    logic    push;
  } kst_cmd_t;

  typedef struct packed {
    action_e act;
    logic    at_end;
    logic    slot_busy;
    logic    same_slot;
    logic    key_hit;
    logic    out_free;
  } kst_sts_t;

endpackage

>>> src/keyed_slot_table_with_compaction.sv
// Operation: one item at a time. Each step visits one slot through the
// registered read of the slot memory. A free or skipped slot is handled in
// S_SCAN alone; a compared or moved slot passes S_SCAN then S_CHECK. The next
// item is taken while a result waits. Reset clears all occupied marks at once;
// no clearing pass.
// ----------------------------------------------------------------------------
// keyed_slot_table_with_compaction
// Slot table with add, lookup, erase and compact over a linear scan.
// ----------------------------------------------------------------------------
module keyed_slot_table_with_compaction
  import kst_pkg::*;
#(
  parameter int unsigned SLOTS = DefSlots
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             action_i,
  input  logic signed [KeyW-1:0] key_i,
  input  logic [InfoW-1:0]       entry_info_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic [InfoW-1:0]       info_out_o
);

  kst_cmd_t cmd;
  kst_sts_t sts;

  kst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kst_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .action_i     (action_i),
    .key_i        (key_i),
    .entry_info_i (entry_info_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .info_out_o   (info_out_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

>>> src/kst_ctrl.sv
// ----------------------------------------------------------------------------
// kst_ctrl
// Sequencer for add, lookup, erase and compact scans over the slot table.
// ----------------------------------------------------------------------------
module kst_ctrl
  import kst_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  kst_sts_t sts_i,
  output kst_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_CHECK  = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.at_end) begin
          if (sts_i.act == ACT_ADD) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_FULL;
          end else if (sts_i.act == ACT_LOOKUP) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_NOTFOUND;
          end
          state_d = S_FINISH;
        end else begin
          unique case (sts_i.act)
            ACT_ADD: begin
              if (!sts_i.slot_busy) begin
                cmd_o.add_slot = 1'b1;
                state_d        = S_FINISH;
              end else begin
                cmd_o.adv_rd = 1'b1;
              end
            end
            ACT_LOOKUP, ACT_ERASE: begin
              if (sts_i.slot_busy) begin
                state_d = S_CHECK;
              end else begin
                cmd_o.adv_rd = 1'b1;
              end
            end
            ACT_COMPACT: begin
              if (sts_i.slot_busy && !sts_i.same_slot) begin
                state_d = S_CHECK;
              end else begin
                cmd_o.adv_rd = 1'b1;
                cmd_o.adv_wr = sts_i.slot_busy;
              end
            end
            default: state_d = S_FINISH;
          endcase
        end
      end
      S_CHECK: begin
        if (sts_i.act == ACT_COMPACT) begin
          cmd_o.move_slot = 1'b1;
          cmd_o.adv_rd    = 1'b1;
          cmd_o.adv_wr    = 1'b1;
          state_d         = S_SCAN;
        end else if (sts_i.key_hit) begin
          cmd_o.set_info  = (sts_i.act == ACT_LOOKUP);
          cmd_o.free_slot = (sts_i.act == ACT_ERASE);
          state_d         = S_FINISH;
        end else begin
          cmd_o.adv_rd = 1'b1;
          state_d      = S_SCAN;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> src/kst_dpath.sv
// ----------------------------------------------------------------------------
// kst_dpath
// Slot storage, scan pointers, operand latch and result register.
// ----------------------------------------------------------------------------
module kst_dpath
  import kst_pkg::*;
#(
  parameter int unsigned SLOTS = DefSlots
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        action_i,
  input  logic signed [KeyW-1:0] key_i,
  input  logic [InfoW-1:0]  entry_info_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [InfoW-1:0]  info_out_o,
  input  kst_cmd_t          cmd_i,
  output kst_sts_t          sts_o
);

  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  action_e                act_q;
  logic signed [KeyW-1:0] key_q;
  logic [InfoW-1:0]       info_q;
  logic [CntW-1:0]        rd_q, wr_q;
  logic [SLOTS-1:0]       busy_q, busy_d;
  status_e                res_status_q;
  logic [InfoW-1:0]       res_info_q;
  logic                   out_valid_q;
  status_e                out_status_q;
  logic [InfoW-1:0]       out_info_q;

  logic signed [KeyW-1:0] key_mem [SLOTS];
  logic [InfoW-1:0]       info_mem [SLOTS];
  logic signed [KeyW-1:0] rd_key_q;
  logic [InfoW-1:0]       rd_info_q;

  logic [IdxW-1:0]        ridx, widx, mem_wa;
  logic                   mem_we;
  logic signed [KeyW-1:0] mem_wkey;
  logic [InfoW-1:0]       mem_winfo;
  logic                   at_end;

  assign ridx   = rd_q[IdxW-1:0];
  assign widx   = wr_q[IdxW-1:0];
  assign at_end = (rd_q == CntW'(SLOTS));

  assign mem_we    = cmd_i.add_slot | cmd_i.move_slot;
  assign mem_wa    = cmd_i.move_slot ? widx : ridx;
  assign mem_wkey  = cmd_i.move_slot ? rd_key_q : key_q;
  assign mem_winfo = cmd_i.move_slot ? rd_info_q : info_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[mem_wa]  <= mem_wkey;
      info_mem[mem_wa] <= mem_winfo;
    end
    rd_key_q  <= key_mem[ridx];
    rd_info_q <= info_mem[ridx];
  end

  always_comb begin
    busy_d = busy_q;
    if (cmd_i.add_slot) begin
      busy_d[ridx] = 1'b1;
    end
    if (cmd_i.free_slot) begin
      busy_d[ridx] = 1'b0;
    end
    if (cmd_i.move_slot) begin
      busy_d[widx] = 1'b1;
      busy_d[ridx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      act_q       <= ACT_ADD;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (cmd_i.load) begin
        act_q <= action_e'(action_i);
        rd_q  <= '0;
        wr_q  <= '0;
      end else begin
        if (cmd_i.adv_rd) begin
          rd_q <= rd_q + CntW'(1);
        end
        if (cmd_i.adv_wr) begin
          wr_q <= wr_q + CntW'(1);
        end
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q        <= key_i;
      info_q       <= entry_info_i;
      res_status_q <= ST_OK;
      res_info_q   <= '0;
    end else begin
      if (cmd_i.set_status) begin
        res_status_q <= cmd_i.status;
      end
      if (cmd_i.set_info) begin
        res_info_q <= rd_info_q;
      end
    end
    if (cmd_i.push) begin
      out_status_q <= res_status_q;
      out_info_q   <= res_info_q;
    end
  end

  assign sts_o.act       = act_q;
  assign sts_o.at_end    = at_end;
  assign sts_o.slot_busy = !at_end && busy_q[ridx];
  assign sts_o.same_slot = (rd_q == wr_q);
  assign sts_o.key_hit   = (rd_key_q == key_q);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign info_out_o  = out_info_q;

endmodule

>>> tb/sv/keyed_slot_table_with_compaction_test.sv
// ----------------------------------------------------------------------------
// keyed_slot_table_with_compaction_test
// Self-checking bench for the keyed slot table. A shadow table predicts the
// status and info of every transfer. Directed cases cover the empty table,
// filling to full, duplicate keys and compaction. Random add, lookup, erase
// and compact traffic then runs under changing source gaps and sink stalls.
// ----------------------------------------------------------------------------
module keyed_slot_table_with_compaction_test
  import kst_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned DrainCycles = 2 * DefSlots + 4;
  localparam int unsigned PoolSize = 6;

  typedef struct packed {
    status_e            status;
    logic [InfoW-1:0]   info;
  } reply_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [1:0]             action_i = ACT_ADD;
  logic signed [KeyW-1:0] key_i = '0;
  logic [InfoW-1:0]       entry_info_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [1:0]             status_o;
  logic [InfoW-1:0]       info_out_o;

  logic                   shadow_busy [DefSlots];
  logic [KeyW-1:0]        shadow_key [DefSlots];
  logic [InfoW-1:0]       shadow_info [DefSlots];
  reply_t                 replies_due_q [$];

  int unsigned            send_idle_pct = 0;
  int unsigned            recv_stall_pct = 0;
  int unsigned            fail_count = 0;
  int unsigned            quiet_cycles = 0;

  keyed_slot_table_with_compaction #(
    .SLOTS(DefSlots)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .key_i       (key_i),
    .entry_info_i(entry_info_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .info_out_o  (info_out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    foreach (shadow_busy[i]) begin
      shadow_busy[i] = 1'b0;
      shadow_key[i]  = '0;
      shadow_info[i] = '0;
    end
  end

  function automatic reply_t apply_table_action(action_e act, logic [KeyW-1:0] k,
                                                logic [InfoW-1:0] inf);
    reply_t rep;
    int     hit;
    int     wr;
    rep.status = ST_OK;
    rep.info   = '0;
    hit        = -1;
    case (act)
      ACT_ADD: begin
        for (int i = 0; i < DefSlots; i++) begin
          if (!shadow_busy[i] && hit < 0) hit = i;
        end
        if (hit >= 0) begin
          shadow_key[hit]  = k;
          shadow_info[hit] = inf;
          shadow_busy[hit] = 1'b1;
        end else begin
          rep.status = ST_FULL;
        end
      end
      ACT_LOOKUP, ACT_ERASE: begin
        for (int i = 0; i < DefSlots; i++) begin
          if (shadow_busy[i] && shadow_key[i] == k && hit < 0) hit = i;
        end
        if (act == ACT_LOOKUP) begin
          if (hit >= 0) rep.info = shadow_info[hit];
          else rep.status = ST_NOTFOUND;
        end else if (hit >= 0) begin
          shadow_busy[hit] = 1'b0;
        end
      end
      default: begin
        wr = 0;
        for (int rd = 0; rd < DefSlots; rd++) begin
          if (shadow_busy[rd]) begin
            if (rd != wr) begin
              shadow_key[wr]  = shadow_key[rd];
              shadow_info[wr] = shadow_info[rd];
              shadow_busy[wr] = 1'b1;
              shadow_busy[rd] = 1'b0;
            end
            wr++;
          end
        end
      end
    endcase
    return rep;
  endfunction

  task automatic send_item(input action_e act, input logic [KeyW-1:0] k,
                           input logic [InfoW-1:0] inf);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    key_i        <= k;
    entry_info_i <= inf;
    do @(posedge clk_i); while (in_stall_o);
    replies_due_q.push_back(apply_table_action(act, k, inf));
  endtask

  always @(posedge clk_i) begin
    reply_t exp_rep;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (replies_due_q.size() == 0) begin
        $display("%0t: unexpected result, status %0d info %h", $time, status_o,
                 info_out_o);
        fail_count++;
      end else begin
        exp_rep = replies_due_q.pop_front();
        if (status_o !== exp_rep.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d", $time,
                   exp_rep.status, status_o);
          fail_count++;
        end
        if (info_out_o !== exp_rep.info) begin
          $display("%0t: info mismatch, expected %h actual %h", $time,
                   exp_rep.info, info_out_o);
          fail_count++;
        end
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("keyed_slot_table_with_compaction test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_empty_table();
    send_item(ACT_LOOKUP, 32'h0000_0000, {$urandom(), $urandom()});
    send_item(ACT_ERASE, 32'h0000_0005, {$urandom(), $urandom()});
  endtask

  task automatic test_fill_and_full();
    logic [KeyW-1:0] k;
    for (int i = 0; i < DefSlots; i++) begin
      case (i)
        0:       k = 32'h8000_0000;
        1:       k = 32'h7FFF_FFFF;
        2, 7:    k = 32'h0000_0000;
        3:       k = 32'hFFFF_FFFF;
        default: k = $urandom();
      endcase
      send_item(ACT_ADD, k, (i == 0) ? '1 : (i == 1) ? '0 : {$urandom(), $urandom()});
    end
    send_item(ACT_ADD, 32'h1234_5678, '1);
  endtask

  task automatic test_lookup_and_erase();
    send_item(ACT_LOOKUP, 32'h8000_0000, '0);
    send_item(ACT_LOOKUP, 32'h0000_0000, '0);
    send_item(ACT_ERASE, 32'h0000_0000, '1);
    send_item(ACT_LOOKUP, 32'h0000_0000, '0);
  endtask

  task automatic test_compact();
    logic [KeyW-1:0] top_key;
    top_key = shadow_key[DefSlots-1];
    send_item(ACT_COMPACT, $urandom(), {$urandom(), $urandom()});
    send_item(ACT_LOOKUP, top_key, '0);
    send_item(ACT_LOOKUP, 32'h7FFF_FFFF, '0);
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    logic [KeyW-1:0] key_pool [PoolSize];
    int              sent;
    int              pick;
    action_e         act;
    logic [KeyW-1:0] k;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        repeat ($urandom_range(4, DefSlots + 2)) begin
          send_item(ACT_ADD, key_pool[$urandom_range(0, PoolSize - 1)],
                    {$urandom(), $urandom()});
          sent++;
        end
      end else if (pick < 10) begin
        repeat ($urandom_range(4, 10)) begin
          send_item(ACT_ERASE, key_pool[$urandom_range(0, PoolSize - 1)],
                    {$urandom(), $urandom()});
          sent++;
        end
      end else begin
        if (pick < 40) act = ACT_ADD;
        else if (pick < 70) act = ACT_LOOKUP;
        else if (pick < 86) act = ACT_ERASE;
        else if (pick < 94) act = ACT_COMPACT;
        else act = action_e'($urandom_range(0, 3));
        k = (pick >= 94) ? $urandom() : key_pool[$urandom_range(0, PoolSize - 1)];
        send_item(act, k, {$urandom(), $urandom()});
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_fill_and_full();
    test_lookup_and_erase();
    test_compact();
    test_random_traffic(113, 0, 0);
    test_random_traffic(113, 81, 0);
    test_random_traffic(113, 0, 81);
    test_random_traffic(113, 36, 36);
    in_valid_i <= 1'b0;
    while (replies_due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("keyed_slot_table_with_compaction test passed");
    end else begin
      $display("keyed_slot_table_with_compaction test failed");
    end
    $finish;
  end

endmodule
